[src/cbhe_pkg.sv]
// Package: command codes, CBOR constants and controller/datapath link types.
package cbhe_pkg;

  localparam int unsigned ADDR_WIDTH_DEF = 16;
  localparam int unsigned CMD_W          = 3;
  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned FILL_W         = 16;
  localparam int unsigned CNT_W          = 4;   // holds up to nine bytes
  localparam int unsigned SEQ_W          = 72;  // head byte + up to eight argument bytes

  localparam logic [FILL_W-1:0] CAP_RESET = 16'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_UINT   = 3'd0,
    CMD_TEXT   = 3'd1,
    CMD_RAW    = 3'd2,
    CMD_FLOAT  = 3'd3,
    CMD_BOOL   = 3'd4,
    CMD_ARRAY  = 3'd5,
    CMD_MAP    = 3'd6,
    CMD_BEGIN  = 3'd7
  } cmd_t;

  localparam logic [2:0] MAJOR_UINT  = 3'd0;
  localparam logic [2:0] MAJOR_TEXT  = 3'd3;
  localparam logic [2:0] MAJOR_ARRAY = 3'd4;
  localparam logic [2:0] MAJOR_MAP   = 3'd5;

  localparam logic [4:0] AI_INLINE_MAX = 5'd23;
  localparam logic [4:0] AI_ONE        = 5'd24;
  localparam logic [4:0] AI_TWO        = 5'd25;
  localparam logic [4:0] AI_FOUR       = 5'd26;
  localparam logic [4:0] AI_EIGHT      = 5'd27;

  localparam logic [7:0] BYTE_FLOAT32 = 8'hFA;
  localparam logic [7:0] BYTE_TRUE    = 8'hF5;
  localparam logic [7:0] BYTE_FALSE   = 8'hF4;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch the accepted item's byte sequence
    logic clear;   // begin frame: zero the fill count
    logic emit;    // move the next byte into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_begin;   // item on the input is a begin frame
    logic last_byte;  // byte being emitted is the item's final one
  } dp_stat_t;

endpackage

[src/cbor_in_if.sv]
// Input channel interface: command and 64-bit argument.
interface cbor_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [63:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

[src/cbor_out_if.sv]
// Result channel interface: one encoded byte per transfer.
interface cbor_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [15:0] out_addr;
  logic        kept;
  logic [15:0] fill_count;
  logic        last;

  modport source (output valid, output out_byte, output out_addr, output kept,
                  output fill_count, output last, input ready);
  modport sink   (input valid, input out_byte, input out_addr, input kept,
                  input fill_count, input last, output ready);
endinterface

[src/cbor_cfg_if.sv]
// Configuration write channel interface: buffer capacity.
interface cbor_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/cbhe_ctrl.sv]
// Controller: sequences item intake and byte emission, owns output valid.
module cbhe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  cbhe_pkg::dp_stat_t stat,
  output cbhe_pkg::dp_cmd_t  cmd
);
  import cbhe_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, emit;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // output register frees up when empty or when its byte transfers now
  assign emit     = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  assign cmd.load  = accept && !stat.is_begin;
  assign cmd.clear = accept && stat.is_begin;
  assign cmd.emit  = emit;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept && !stat.is_begin) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          if (stat.last_byte) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/cbhe_dp.sv]
// Datapath: head encoding, byte shift register, fill count and output register.
module cbhe_dp #(
  parameter int unsigned ADDR_WIDTH = cbhe_pkg::ADDR_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_cmd,
  input  logic [63:0]        in_value,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  cbhe_pkg::dp_cmd_t  cmd,
  output cbhe_pkg::dp_stat_t stat,
  output logic [7:0]         out_byte,
  output logic [15:0]        out_addr,
  output logic               out_kept,
  output logic [15:0]        out_fill,
  output logic               out_last
);
  import cbhe_pkg::*;

  // highest fill the address space allows: 2^ADDR_WIDTH - 1
  localparam logic [32:0] ADDR_LIMIT = (33'd1 << ADDR_WIDTH) - 33'd1;

  logic [FILL_W-1:0] cap_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SEQ_W-1:0]  seq_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [7:0]        byte_r;
  logic [15:0]       addr_r;
  logic              kept_r;
  logic [15:0]       fill_out_r;
  logic              last_r;

  logic [SEQ_W-1:0]  seq_load;
  logic [CNT_W-1:0]  cnt_load;
  logic [2:0]        major;
  logic              fits;

  // encode the item into head byte + left-aligned argument bytes
  always_comb begin
    major    = MAJOR_UINT;
    seq_load = '0;
    cnt_load = CNT_W'(1);
    case (cmd_t'(in_cmd))
      CMD_TEXT:  major = MAJOR_TEXT;
      CMD_ARRAY: major = MAJOR_ARRAY;
      CMD_MAP:   major = MAJOR_MAP;
      default:   major = MAJOR_UINT;
    endcase
    case (cmd_t'(in_cmd))
      CMD_RAW: begin
        seq_load = {in_value[7:0], 64'd0};
      end
      CMD_FLOAT: begin
        seq_load = {BYTE_FLOAT32, in_value[31:0], 32'd0};
        cnt_load = CNT_W'(5);
      end
      CMD_BOOL: begin
        seq_load = {(in_value[0] ? BYTE_TRUE : BYTE_FALSE), 64'd0};
      end
      CMD_BEGIN: begin
        seq_load = '0;
      end
      default: begin
        if (in_value <= {59'd0, AI_INLINE_MAX}) begin
          seq_load = {major, in_value[4:0], 64'd0};
        end else if (in_value[63:8] == '0) begin
          seq_load = {major, AI_ONE, in_value[7:0], 56'd0};
          cnt_load = CNT_W'(2);
        end else if (in_value[63:16] == '0) begin
          seq_load = {major, AI_TWO, in_value[15:0], 48'd0};
          cnt_load = CNT_W'(3);
        end else if (in_value[63:32] == '0) begin
          seq_load = {major, AI_FOUR, in_value[31:0], 32'd0};
          cnt_load = CNT_W'(5);
        end else begin
          seq_load = {major, AI_EIGHT, in_value};
          cnt_load = CNT_W'(9);
        end
      end
    endcase
  end

  assign fits     = (fill_r < cap_r) && ({17'd0, fill_r} < ADDR_LIMIT);
  assign fill_nxt = fits ? fill_r + FILL_W'(1) : fill_r;

  assign stat.is_begin  = (cmd_t'(in_cmd) == CMD_BEGIN);
  assign stat.last_byte = (cnt_r == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      fill_r <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (cmd.clear) begin
        fill_r <= '0;
      end else if (cmd.emit) begin
        fill_r <= fill_nxt;
      end
    end
  end

  // sequence and output payload need no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_r <= seq_load;
      cnt_r <= cnt_load;
    end else if (cmd.emit) begin
      seq_r <= {seq_r[SEQ_W-9:0], 8'd0};
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.emit) begin
      byte_r     <= seq_r[SEQ_W-1 -: 8];
      addr_r     <= fill_r;
      kept_r     <= fits;
      fill_out_r <= fill_nxt;
      last_r     <= stat.last_byte;
    end
  end

  assign out_byte = byte_r;
  assign out_addr = addr_r;
  assign out_kept = kept_r;
  assign out_fill = fill_out_r;
  assign out_last = last_r;

endmodule

[src/cbor_item_head_encoder_unit.sv]
// Top level: bounded CBOR item head encoder, controller plus datapath.
//
// Usage notes:
// - in_if carries one command (cmd) and a 64-bit argument (value) per transfer.
//   Commands: uint, text head, raw byte, float32 bits, bool, array head,
//   map head, begin frame.
// - out_if carries one encoded byte per transfer with its buffer address,
//   kept flag (0 when the buffer is full), the fill count after the byte
//   and last on the final byte of the item.
// - cfg_if writes buffer_capacity (reset 1024); write only while idle.
// - An item produces N bytes (1..9); the byte sequencer emits one byte per
//   cycle, unless the output stalls, out of a 72-bit shift register.
//   A begin frame produces no transfer.
// - The input transfer fills the shift register; the first byte follows.
// - The next item is accepted as soon as the last byte sits in the output
//   register, even while that byte waits to be taken.
// - A stalled receiver holds the output register; the sequencer waits.
// - Synchronous active-low reset clears the fill count, the controller and
//   the output valid, and sets the capacity to 1024.
module cbor_item_head_encoder_unit #(
  parameter int unsigned ADDR_WIDTH = cbhe_pkg::ADDR_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cbor_in_if.sink    in_if,
  cbor_out_if.source out_if,
  cbor_cfg_if.sink   cfg_if
);
  import cbhe_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     in_ready;
  logic     out_valid;

  // capacity register always takes a write
  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

  cbhe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  cbhe_dp #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_cmd   (in_if.cmd),
    .in_value (in_if.value),
    .cfg_we   (cfg_if.valid),
    .cfg_data (cfg_if.data),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .out_byte (out_if.out_byte),
    .out_addr (out_if.out_addr),
    .out_kept (out_if.kept),
    .out_fill (out_if.fill_count),
    .out_last (out_if.last)
  );

endmodule

[test/tb_cbor_item_head_encoder_unit.sv]
// Testbench for cbor_item_head_encoder_unit: directed and random CBOR items against an in-bench encoder.
`timescale 1ns / 100ps

module tb_cbor_item_head_encoder_unit;
  import cbhe_pkg::*;

  // One expected output transfer: an encoded byte and its bookkeeping.
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] addr;
    logic        kept;
    logic [15:0] fill;
    logic        last;
  } enc_byte_t;

  localparam int          WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int          RX_HOLD_CYCLES = 250;   // long receiver hold-off
  localparam logic [15:0] ADDR_CEIL      = 16'hFFFF;

  logic clk;
  logic rst_n;

  cbor_in_if  in_ch();
  cbor_out_if res_ch();
  cbor_cfg_if cfg_ch();

  cbor_item_head_encoder_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (res_ch),
    .cfg_if (cfg_ch)
  );

  // Encoder state as the bench sees it: fill count and capacity register.
  logic [15:0] fill_len;
  logic [15:0] cap_reg;

  // Bytes expected on the result channel, oldest first.
  enc_byte_t pending_bytes[$];
  // Bytes of the item being predicted; "last" gets set once the item is complete.
  enc_byte_t item_seq[$];

  int mismatches;
  int rx_hold_req;  // receiver hold-off request, consumed one cycle at a time
  bit no_gaps;      // both sides run flat out while set, bar a hold-off request

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Encoder prediction
  // ---------------------------------------------------------------------------

  // Append one byte at the current fill position. A byte is stored only while
  // there is room under the capacity and under the address ceiling; a dropped
  // byte still goes out, with kept low and the fill count unchanged.
  task automatic push_byte(input logic [7:0] b);
    enc_byte_t e;
    e.data = b;
    e.addr = fill_len;
    e.kept = (fill_len < cap_reg) && (fill_len < ADDR_CEIL);
    if (e.kept)
      fill_len = fill_len + 16'd1;
    e.fill = fill_len;
    e.last = 1'b0;
    item_seq.push_back(e);
  endtask

  // CBOR head: inline argument up to 23, else 1/2/4/8 big-endian bytes follow.
  task automatic push_head(input logic [2:0] major, input logic [63:0] arg);
    logic [7:0] mt;
    int         nbytes;
    mt = {major, 5'd0};
    if (arg <= AI_INLINE_MAX) begin
      push_byte(mt | {3'd0, arg[4:0]});
      return;
    end
    if (arg <= 64'hFF) begin
      push_byte(mt | {3'd0, AI_ONE});
      nbytes = 1;
    end else if (arg <= 64'hFFFF) begin
      push_byte(mt | {3'd0, AI_TWO});
      nbytes = 2;
    end else if (arg <= 64'hFFFF_FFFF) begin
      push_byte(mt | {3'd0, AI_FOUR});
      nbytes = 4;
    end else begin
      push_byte(mt | {3'd0, AI_EIGHT});
      nbytes = 8;
    end
    for (int i = nbytes - 1; i >= 0; i--)
      push_byte(arg[i*8 +: 8]);
  endtask

  // Work out every byte one accepted item causes and queue them.
  task automatic encode_item(input cmd_t c, input logic [63:0] v);
    enc_byte_t tail;
    item_seq.delete();
    case (c)
      CMD_UINT:  push_head(MAJOR_UINT, v);
      CMD_TEXT:  push_head(MAJOR_TEXT, v);
      CMD_RAW:   push_byte(v[7:0]);
      CMD_FLOAT: begin
        push_byte(BYTE_FLOAT32);
        for (int i = 3; i >= 0; i--)
          push_byte(v[i*8 +: 8]);
      end
      CMD_BOOL:  push_byte(v[0] ? BYTE_TRUE : BYTE_FALSE);
      CMD_ARRAY: push_head(MAJOR_ARRAY, v);
      CMD_MAP:   push_head(MAJOR_MAP, v);
      default:   fill_len = 16'd0;  // begin frame: no bytes
    endcase
    if (item_seq.size() > 0) begin
      tail = item_seq[item_seq.size()-1];
      tail.last = 1'b1;
      item_seq[item_seq.size()-1] = tail;
    end
    foreach (item_seq[i])
      pending_bytes.push_back(item_seq[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Argument spread over every head size, with the size boundaries favored.
  function automatic logic [63:0] pick_value();
    logic [63:0] full;
    logic [63:0] edge_v;
    full = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return 64'($urandom_range(0, 23));
      1:       return 64'($urandom_range(24, 255));
      2:       return 64'($urandom_range(256, 65535));
      3:       return {32'd0, $urandom};
      4, 5:    return full;
      default: begin
        case ($urandom_range(0, 3))
          0:       edge_v = 64'd24;
          1:       edge_v = 64'd256;
          2:       edge_v = 64'h1_0000;
          default: edge_v = 64'h1_0000_0000;
        endcase
        return $urandom_range(0, 1) ? edge_v : edge_v - 64'd1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one item after a random gap and predict it at its transfer. Valid is
  // left high on return so that a back-to-back item keeps it high; stop_input
  // lowers it whenever the sender stops.
  task automatic send_item(input cmd_t c, input logic [63:0] v);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd   = c;
    in_ch.value = v;
    do @(posedge clk); while (!in_ch.ready);
    encode_item(c, v);
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Sender pause: nothing offered until every queued byte has come out.
  task automatic drain_results();
    stop_input();
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Full idle: drained, plus a few cycles for a trailing begin frame, which
  // produces no transfer but still clears the fill count.
  task automatic wait_idle();
    drain_results();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] cap);
    wait_idle();
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = cap;
    do @(posedge clk); while (!cfg_ch.ready);
    cap_reg = cap;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, flat-out stretches, and the long hold-off
  // that a test requests through rx_hold_req.
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    int stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        res_ch.ready = 1'b0;
        rx_hold_req--;
      end else if (no_gaps) begin
        res_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else begin
        res_ch.ready = 1'b1;
        if ($urandom_range(0, 3) == 0)
          stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: every transfer against the oldest expected byte.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    enc_byte_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: byte %02h at %0d with nothing expected", $realtime,
                   res_ch.out_byte, res_ch.out_addr);
      end else begin
        want = pending_bytes.pop_front();
        check_field("out_byte",   16'(want.data), 16'(res_ch.out_byte));
        check_field("out_addr",   want.addr,      res_ch.out_addr);
        check_field("kept",       16'(want.kept), 16'(res_ch.kept));
        check_field("fill_count", want.fill,      res_ch.fill_count);
        check_field("last",       16'(want.last), 16'(res_ch.last));
      end
    end
  end

  // Watchdog: too long without any transfer on any channel ends the run.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("tb_cbor_item_head_encoder_unit: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Unsigned heads at every size boundary, at the reset capacity of 1024.
  task automatic test_head_widths();
    send_item(CMD_UINT, 64'd0);
    send_item(CMD_UINT, 64'd23);
    send_item(CMD_UINT, 64'd24);
    send_item(CMD_UINT, 64'hFF);
    send_item(CMD_UINT, 64'h100);
    send_item(CMD_UINT, 64'hFFFF);
    send_item(CMD_UINT, 64'h1_0000);
    send_item(CMD_UINT, 64'hFFFF_FFFF);
    send_item(CMD_UINT, 64'h1_0000_0000);
    send_item(CMD_UINT, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // Text, array and map heads carry their own major type.
  task automatic test_other_majors();
    send_item(CMD_TEXT,  64'd24);
    send_item(CMD_ARRAY, 64'h1_0000_0000);
    send_item(CMD_MAP,   64'hFFFF);
  endtask

  // Raw byte, float32 and bool use only their low bits.
  task automatic test_scalars();
    send_item(CMD_RAW,   64'hABCD_EF12_3456_7899);
    send_item(CMD_FLOAT, 64'hDEAD_BEEF_3FC0_0001);
    send_item(CMD_BOOL,  64'h1);
    send_item(CMD_BOOL,  64'hFFFF_FFFF_FFFF_FFFE);
  endtask

  // Tiny buffer: the head that crosses the capacity loses its tail byte, later
  // items are dropped whole, and a begin frame restarts storing at address 0.
  task automatic test_buffer_full();
    write_capacity(16'd5);
    send_item(CMD_BEGIN, 64'd0);
    send_item(CMD_UINT,  64'h1234);
    send_item(CMD_TEXT,  64'd300);
    send_item(CMD_BOOL,  64'd0);
    send_item(CMD_BEGIN, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(CMD_RAW,   64'h5A);
  endtask

  // Random items at one capacity; begin frames do not count toward n_items.
  // The sender pauses to drain the results halfway through and now and then.
  task automatic test_random_traffic(input int n_items, input logic [15:0] cap);
    int   sent;
    cmd_t c;
    write_capacity(cap);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 8)
        c = CMD_BEGIN;
      else
        c = cmd_t'($urandom_range(CMD_UINT, CMD_MAP));
      send_item(c, pick_value());
      if (c != CMD_BEGIN)
        sent++;
      if (sent == n_items / 2 || $urandom_range(0, 99) < 4)
        drain_results();
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the output register and the sequencer back up into the input.
  task automatic test_receiver_hold();
    wait_idle();
    rx_hold_req = RX_HOLD_CYCLES;
    no_gaps = 1'b1;
    repeat (15)
      send_item(cmd_t'($urandom_range(CMD_UINT, CMD_MAP)), pick_value());
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_UINT;
    in_ch.value  = 64'd0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = 16'd0;
    fill_len     = 16'd0;
    cap_reg      = CAP_RESET;
    mismatches   = 0;
    rx_hold_req  = 0;
    no_gaps      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_head_widths();
    test_other_majors();
    test_scalars();
    test_buffer_full();
    test_random_traffic(30, 16'd1024);
    test_random_traffic(15, 16'($urandom_range(16, 64)));
    test_random_traffic(8, 16'd0);
    test_receiver_hold();
    test_random_traffic(15, 16'hFFFF);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("tb_cbor_item_head_encoder_unit: PASS");
    else
      $display("tb_cbor_item_head_encoder_unit: FAIL");
    $finish;
  end

endmodule
